>>> rtl/jstp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstp_pkg
// Types, opcodes and character tables shared by the JSON token packer.
// ----------------------------------------------------------------------------
package jstp_pkg;

    localparam int DIGITS      = 20;
    localparam int DIGIT_IDX_W = 5;

    localparam logic [3:0] OP_INT      = 4'd0;
    localparam logic [3:0] OP_BOOL     = 4'd1;
    localparam logic [3:0] OP_NULL     = 4'd2;
    localparam logic [3:0] OP_LBRACE   = 4'd3;
    localparam logic [3:0] OP_RBRACE   = 4'd4;
    localparam logic [3:0] OP_LBRACKET = 4'd5;
    localparam logic [3:0] OP_RBRACKET = 4'd6;
    localparam logic [3:0] OP_COMMA    = 4'd7;
    localparam logic [3:0] OP_COLON    = 4'd8;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // left aligned, padded to five characters
    localparam logic [39:0] WORD_TRUE  = {"true", 8'h00};
    localparam logic [39:0] WORD_FALSE = "false";
    localparam logic [39:0] WORD_NULL  = {"null", 8'h00};

    typedef struct packed {
        logic [3:0]        opcode;
        logic signed [63:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } out_item_t;

    typedef enum logic [2:0] {
        KIND_INT,
        KIND_TRUE,
        KIND_FALSE,
        KIND_NULL,
        KIND_PUNCT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       neg;
        logic [7:0] punct;
    } cmd_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] punct_char(logic [3:0] op);
        logic [7:0] c;
        case (op)
            OP_LBRACE:   c = "{";
            OP_RBRACE:   c = "}";
            OP_LBRACKET: c = "[";
            OP_RBRACKET: c = "]";
            OP_COMMA:    c = ",";
            OP_COLON:    c = ":";
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] word_char(kind_t k, logic [2:0] pos);
        logic [39:0] w;
        logic [39:0] sh;
        case (k)
            KIND_TRUE:  w = WORD_TRUE;
            KIND_FALSE: w = WORD_FALSE;
            KIND_NULL:  w = WORD_NULL;
            default:    w = '0;
        endcase
        sh = w << {pos, 3'b000};
        return sh[39:32];
    endfunction

    function automatic logic [2:0] word_last(kind_t k);
        logic [2:0] n;
        case (k)
            KIND_FALSE: n = 3'd4;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/jstp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstp_front
// Accepts token requests, decodes the opcode and forms the integer magnitude.
// ----------------------------------------------------------------------------
module jstp_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                     s_valid,
    output logic                     s_ready,
    input  jstp_pkg::in_item_t       s_item,
    input  logic                     q_full,
    output logic                     q_push,
    output jstp_pkg::cmd_ctl_t       q_ctl,
    output logic [VALUE_BITS-1:0]    q_mag
);

    logic [VALUE_BITS-1:0] v;
    logic                  neg;
    logic                  op_ok;

    assign v       = s_item.value[VALUE_BITS-1:0];
    assign neg     = v[VALUE_BITS-1];
    assign s_ready = !q_full;
    assign q_mag   = neg ? (~v) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : v;
    assign q_push  = s_valid && s_ready && op_ok;

    always_comb begin
        op_ok       = 1'b1;
        q_ctl.kind  = jstp_pkg::KIND_PUNCT;
        q_ctl.neg   = 1'b0;
        q_ctl.punct = jstp_pkg::punct_char(s_item.opcode);
        case (s_item.opcode)
            jstp_pkg::OP_INT: begin
                q_ctl.kind = jstp_pkg::KIND_INT;
                q_ctl.neg  = neg;
            end
            jstp_pkg::OP_BOOL: begin
                q_ctl.kind = (|v) ? jstp_pkg::KIND_TRUE : jstp_pkg::KIND_FALSE;
            end
            jstp_pkg::OP_NULL: begin
                q_ctl.kind = jstp_pkg::KIND_NULL;
            end
            jstp_pkg::OP_LBRACE, jstp_pkg::OP_RBRACE, jstp_pkg::OP_LBRACKET,
            jstp_pkg::OP_RBRACKET, jstp_pkg::OP_COMMA, jstp_pkg::OP_COLON: begin
                q_ctl.kind = jstp_pkg::KIND_PUNCT;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/jstp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstp_queue
// Two-entry command queue between the decode front and the emit back end.
// ----------------------------------------------------------------------------
module jstp_queue #(
    parameter int WIDTH = 76
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             nempty
);

    logic [WIDTH-1:0] entries_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full   = count_reg[1];
    assign nempty = count_reg != 2'd0;
    assign dout   = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/jstp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstp_back
// Runs one command: for integers, bit-serial binary to BCD conversion, then byte
// emission through an output register; other tokens go straight to emission.
// ----------------------------------------------------------------------------
module jstp_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_nempty,
    input  jstp_pkg::cmd_ctl_t    q_ctl,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output jstp_pkg::out_item_t   m_item
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int IW    = jstp_pkg::DIGIT_IDX_W;

    jstp_pkg::state_t                            state_reg, state_next;
    jstp_pkg::cmd_ctl_t                          ctl_reg, ctl_next;
    logic [VALUE_BITS-1:0]                       shift_reg, shift_next;
    logic [jstp_pkg::DIGITS-1:0][3:0]            bcd_reg, bcd_next;
    logic [jstp_pkg::DIGITS-1:0][3:0]            bcd_adj;
    logic [jstp_pkg::DIGITS*4-1:0]               bcd_flat;
    logic [CNT_W-1:0]                            cnt_reg, cnt_next;
    logic [IW-1:0]                               idx_reg, idx_next;
    logic [IW-1:0]                               top_idx;
    logic                                        sign_reg, sign_next;
    logic                                        m_valid_reg, m_valid_next;
    jstp_pkg::out_item_t                         m_item_reg, m_item_next;
    logic                                        load_ok;

    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign load_ok  = !m_valid_reg || m_ready;
    assign bcd_flat = bcd_adj;

    always_comb begin
        for (int i = 0; i < jstp_pkg::DIGITS; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb begin
        top_idx = '0;
        for (int i = 0; i < jstp_pkg::DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                top_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jstp_pkg::ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg    <= ctl_next;
        shift_reg  <= shift_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        sign_reg   <= sign_next;
        m_item_reg <= m_item_next;
    end

    always_comb begin
        state_next   = state_reg;
        ctl_next     = ctl_reg;
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        sign_next    = sign_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        case (state_reg)
            jstp_pkg::ST_IDLE: begin
                if (q_nempty) begin
                    q_pop      = 1'b1;
                    ctl_next   = q_ctl;
                    shift_next = q_mag;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    sign_next  = q_ctl.neg;
                    idx_next   = '0;
                    state_next = (q_ctl.kind == jstp_pkg::KIND_INT) ?
                                 jstp_pkg::ST_CONV : jstp_pkg::ST_EMIT;
                end
            end
            jstp_pkg::ST_CONV: begin
                bcd_next   = {bcd_flat[jstp_pkg::DIGITS*4-2:0], shift_reg[VALUE_BITS-1]};
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = jstp_pkg::ST_FIND;
                end
            end
            jstp_pkg::ST_FIND: begin
                idx_next   = top_idx;
                state_next = jstp_pkg::ST_EMIT;
            end
            jstp_pkg::ST_EMIT: begin
                if (load_ok) begin
                    m_valid_next = 1'b1;
                    case (ctl_reg.kind)
                        jstp_pkg::KIND_INT: begin
                            if (sign_reg) begin
                                m_item_next.char_code = jstp_pkg::CHAR_MINUS;
                                m_item_next.last      = 1'b0;
                                sign_next             = 1'b0;
                            end else begin
                                m_item_next.char_code = jstp_pkg::CHAR_ZERO +
                                                        {4'b0000, bcd_reg[idx_reg]};
                                m_item_next.last      = idx_reg == '0;
                                idx_next              = idx_reg - IW'(1);
                                if (idx_reg == '0) begin
                                    idx_next   = '0;
                                    state_next = jstp_pkg::ST_IDLE;
                                end
                            end
                        end
                        jstp_pkg::KIND_TRUE, jstp_pkg::KIND_FALSE,
                        jstp_pkg::KIND_NULL: begin
                            m_item_next.char_code = jstp_pkg::word_char(ctl_reg.kind,
                                                                        idx_reg[2:0]);
                            m_item_next.last      = idx_reg[2:0] ==
                                                    jstp_pkg::word_last(ctl_reg.kind);
                            idx_next              = idx_reg + IW'(1);
                            if (m_item_next.last) begin
                                idx_next   = '0;
                                state_next = jstp_pkg::ST_IDLE;
                            end
                        end
                        default: begin
                            m_item_next.char_code = ctl_reg.punct;
                            m_item_next.last      = 1'b1;
                            idx_next              = '0;
                            state_next            = jstp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = jstp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/json_scalar_token_packer_unit.sv
`timescale 1ns / 1ps
// Flow: an accepted request waits in the queue; an integer then passes the
//   one-bit-per-cycle BCD converter (ST_CONV) and the top-digit search (ST_FIND),
//   other tokens go straight to emission; then one byte per cycle while
//   m_ready allows. The queue accepts new requests while a command runs.
// Reset: synchronous active-low aresetn empties the queue, idles the
//   sequencer and drops m_valid.
// ----------------------------------------------------------------------------
// json_scalar_token_packer_unit
// Turns one scalar token request into its JSON text, one ASCII byte per item.
// ----------------------------------------------------------------------------
module json_scalar_token_packer_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jstp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output jstp_pkg::out_item_t m_item
);

    localparam int CTL_W = $bits(jstp_pkg::cmd_ctl_t);
    localparam int Q_W   = CTL_W + VALUE_BITS;

    jstp_pkg::cmd_ctl_t    f_ctl;
    logic [VALUE_BITS-1:0] f_mag;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_nempty;
    logic [Q_W-1:0]        q_dout;

    jstp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_ctl   (f_ctl),
        .q_mag   (f_mag)
    );

    jstp_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({f_ctl, f_mag}),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .nempty  (q_nempty)
    );

    jstp_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_nempty (q_nempty),
        .q_ctl    (jstp_pkg::cmd_ctl_t'(q_dout[Q_W-1:VALUE_BITS])),
        .q_mag    (q_dout[VALUE_BITS-1:0]),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

>>> rtl/jstp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstp_checker
// Port-level checks on the token packer's result channel.
// ----------------------------------------------------------------------------
module jstp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input jstp_pkg::out_item_t m_item
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_item.char_code[7])
        else $error("non-ASCII byte");

    a_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.char_code == jstp_pkg::CHAR_MINUS |-> !m_item.last)
        else $error("minus sign ends a token");

    a_punct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.char_code == 8'h7B || m_item.char_code == 8'h7D ||
                    m_item.char_code == 8'h5B || m_item.char_code == 8'h5D ||
                    m_item.char_code == 8'h2C || m_item.char_code == 8'h3A)
        |-> m_item.last)
        else $error("punctuation not flagged last");

endmodule

bind json_scalar_token_packer_unit jstp_checker u_jstp_checker (.*);
